// ===== hdl/assert_macros.svh =====
// assertion macros for the md5 digest unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
// types, constants and round functions shared by the md5 digest unit
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // message word index used by round i
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'((i[3:0] * 4'd5) + 4'd1);
                2'd2: g = 4'((i[3:0] * 4'd3) + 4'd5);
                default: g = 4'(i[3:0] * 4'd7);
            endcase
            return g;
        end
    endfunction

endpackage

// ===== hdl/md5_round.sv =====
// one md5 round step: mixing function, add chain and rotate
module md5_round (
    input  logic [5:0]  idx,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] w,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [63:0] dbl;

    always_comb
    begin
        case (idx[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        sum = a + f + md5_pkg::round_k(idx) + w;
        s = md5_pkg::round_s(idx);
        dbl = {sum, sum} << s;
        b_new = b + dbl[63:32];
    end

endmodule

// ===== hdl/md5_message_digest_unit.sv =====
// md5 digest unit top level: word memory, round sequencer, padding and output
// Message bytes are packed into a 16-word block memory (one synchronous write
// and one synchronous read port). Byte transactions are accepted while idle;
// every 64th byte starts compression: a read-ahead load step, 64 rounds at
// one per cycle and a fold step. A last transaction pads the remaining bytes
// one per cycle while padding, pausing to compress each full block (one or
// two blocks), then offers the four digest words in order.
`include "assert_macros.svh"
module md5_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    md5_pkg::state_t state_reg, state_next;

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;
    logic [31:0] wbuf_reg, wbuf_next;
    logic        we;
    logic [3:0]  wa;
    logic [31:0] wd;
    logic [3:0]  ra;

    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        pad_reg, pad_next;
    logic        tail_reg, tail_next;
    logic        len_reg, len_next;
    logic [1:0]  oi_reg, oi_next;
    logic        start_round, do_fold, clr_chain;
    logic [31:0] b_new;
    logic [7:0]  byte_w;
    logic        put;
    logic [7:0]  lenb;
    logic        in_emit;
    logic        digest_done;

    md5_round u_round (
        .idx   (rnd_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .w     (rd_data_reg),
        .b_new (b_new)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    always_comb
    begin
        case (pos_reg[2:0])
            3'd0: lenb = bits_reg[7:0];
            3'd1: lenb = bits_reg[15:8];
            3'd2: lenb = bits_reg[23:16];
            3'd3: lenb = bits_reg[31:24];
            3'd4: lenb = bits_reg[39:32];
            3'd5: lenb = bits_reg[47:40];
            3'd6: lenb = bits_reg[55:48];
            default: lenb = bits_reg[63:56];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        bits_next = bits_reg;
        pos_next = pos_reg;
        rnd_next = rnd_reg;
        pad_next = pad_reg;
        tail_next = tail_reg;
        len_next = len_reg;
        oi_next = oi_reg;
        wbuf_next = wbuf_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        put = 1'b0;
        byte_w = data_byte;
        start_round = 1'b0;
        do_fold = 1'b0;
        clr_chain = 1'b0;
        ra = md5_pkg::round_g(rnd_reg);
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        put = 1'b1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (is_last)
                    begin
                        pad_next = 1'b1;
                        tail_next = 1'b1;
                        if (!(has_byte && pos_reg == 6'd63))
                        begin
                            state_next = md5_pkg::ST_PAD;
                        end
                    end
                    if (has_byte && pos_reg == 6'd63)
                    begin
                        state_next = md5_pkg::ST_LOAD;
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                put = 1'b1;
                if (pad_reg)
                begin
                    byte_w = md5_pkg::PAD_BYTE;
                    pad_next = 1'b0;
                    len_next = (pos_reg < md5_pkg::LEN_POS);
                end
                else if (len_reg && pos_reg >= md5_pkg::LEN_POS)
                begin
                    byte_w = lenb;
                end
                else
                begin
                    byte_w = 8'h00;
                end
                if (pos_reg == 6'd63)
                begin
                    len_next = 1'b1;
                    state_next = md5_pkg::ST_LOAD;
                end
            end
            md5_pkg::ST_LOAD:
            begin
                ra = md5_pkg::round_g(6'd0);
                start_round = 1'b1;
                rnd_next = 6'd0;
                state_next = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_ROUND:
            begin
                ra = md5_pkg::round_g(6'(rnd_reg + 6'd1));
                rnd_next = 6'(rnd_reg + 6'd1);
                if (rnd_reg == 6'd63)
                begin
                    state_next = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD:
            begin
                do_fold = 1'b1;
                if (tail_reg)
                begin
                    state_next = md5_pkg::ST_PAD;
                end
                else
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    oi_next = 2'(oi_reg + 2'd1);
                    if (oi_reg == 2'd3)
                    begin
                        clr_chain = 1'b1;
                        bits_next = 64'd0;
                        tail_next = 1'b0;
                        len_next = 1'b0;
                        state_next = md5_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
        if (put)
        begin
            pos_next = 6'(pos_reg + 6'd1);
            case (pos_reg[1:0])
                2'd0: wbuf_next = {24'h0, byte_w};
                2'd1: wbuf_next = {wbuf_reg[31:16], byte_w, wbuf_reg[7:0]};
                2'd2: wbuf_next = {wbuf_reg[31:24], byte_w, wbuf_reg[15:0]};
                default: wbuf_next = {byte_w, wbuf_reg[23:0]};
            endcase
        end
    end

    // fold completes the message once the block holding the length is full
    logic fin_reg, fin_next;

    always_comb
    begin
        fin_next = fin_reg;
        if (state_reg == md5_pkg::ST_PAD && len_reg && pos_reg == 6'd63)
        begin
            fin_next = 1'b1;
        end
        if (clr_chain)
        begin
            fin_next = 1'b0;
        end
    end

    assign we = put && (pos_reg[1:0] == 2'd3);
    assign wa = pos_reg[5:2];
    assign wd = {byte_w, wbuf_reg[23:0]};

    md5_pkg::state_t state_final;
    always_comb
    begin
        state_final = state_next;
        if (state_reg == md5_pkg::ST_FOLD && fin_reg)
        begin
            state_final = md5_pkg::ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::ST_IDLE;
            bits_reg <= 64'd0;
            pos_reg <= 6'd0;
            rnd_reg <= 6'd0;
            pad_reg <= 1'b0;
            tail_reg <= 1'b0;
            len_reg <= 1'b0;
            oi_reg <= 2'd0;
            fin_reg <= 1'b0;
            h_reg[0] <= md5_pkg::INIT_A;
            h_reg[1] <= md5_pkg::INIT_B;
            h_reg[2] <= md5_pkg::INIT_C;
            h_reg[3] <= md5_pkg::INIT_D;
        end
        else
        begin
            state_reg <= state_final;
            bits_reg <= bits_next;
            pos_reg <= pos_next;
            rnd_reg <= rnd_next;
            pad_reg <= pad_next;
            tail_reg <= tail_next;
            len_reg <= len_next;
            oi_reg <= oi_next;
            fin_reg <= fin_next;
            if (do_fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
            else if (clr_chain)
            begin
                h_reg[0] <= md5_pkg::INIT_A;
                h_reg[1] <= md5_pkg::INIT_B;
                h_reg[2] <= md5_pkg::INIT_C;
                h_reg[3] <= md5_pkg::INIT_D;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wbuf_reg <= wbuf_next;
        if (start_round)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        else if (state_reg == md5_pkg::ST_ROUND)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    assign digest_word = h_reg[oi_reg];
    assign word_index = oi_reg;
    assign last_word = (oi_reg == 2'd3);

    assign in_emit = (state_reg == md5_pkg::ST_EMIT);
    assign digest_done = out_valid && out_ready && last_word;

    `ASSERT_ALWAYS(a_out_idle, clk, rst_n, !out_valid || !in_ready, "output and input overlap")
    `ASSERT_ALWAYS(a_round_ptr, clk, rst_n, !in_emit || pos_reg == 6'd0, "emit mid block")
    `ASSERT_NEXT(a_wrap, clk, rst_n, digest_done, state_reg == md5_pkg::ST_IDLE, "no wrap")

endmodule

// ===== tb/md5_message_digest_unit_tb.sv =====
// self-checking testbench for the md5 digest unit with a built-in digest predictor
`timescale 1ns / 1ps
module md5_message_digest_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_out_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       known;
        logic [31:0] dig0;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    md5_message_digest_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    logic [31:0] hash_state [4];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;
    logic [5:0]  msg_pos;
    digest_out_t digest_queue [$];
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] known_word0 [$];

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] md5_const(input int i);
        real x;
        x = $sin(i + 1);
        if (x < 0) x = -x;
        return 32'(longint'($floor(x * 4294967296.0)));
    endfunction

    task automatic md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g, s;
        int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            s = shifts[((i / 16) * 4) + (i % 4)];
            t = d; d = c; c = b;
            b = b + rot_left(a + f + md5_const(i) + w[g], s);
            a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    endtask

    task automatic md5_absorb(input logic [7:0] v);
        msg_block[msg_pos] = v;
        msg_pos = 6'(msg_pos + 6'd1);
        if (msg_pos == 0)
            md5_compress();
    endtask

    task automatic md5_restart();
        hash_state[0] = INIT_A; hash_state[1] = INIT_B;
        hash_state[2] = INIT_C; hash_state[3] = INIT_D;
        msg_bits = 0;
        msg_pos = 0;
    endtask

    task automatic md5_predict(input logic [7:0] d, input logic h, input logic l);
        logic [63:0] len;
        if (h)
        begin
            md5_absorb(d);
            msg_bits += 8;
        end
        if (l)
        begin
            len = msg_bits;
            md5_absorb(8'h80);
            while (msg_pos != 6'd56)
                md5_absorb(8'h00);
            for (int k = 0; k < 8; k++)
                md5_absorb(len[8*k +: 8]);
            for (int k = 0; k < 4; k++)
                digest_queue.push_back('{hash_state[k], 2'(k), k == 3});
            md5_restart();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // digest transaction checking
    always @(posedge clk)
    begin
        digest_out_t exp_out;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h index %0d", digest_word, word_index);
            end
            else
            begin
                exp_out = digest_queue.pop_front();
                if (exp_out.index == 0 && known_word0.size() > 0)
                    exp_out.word = known_word0.pop_front() | (exp_out.word & 0);
                if (digest_word !== exp_out.word || word_index !== exp_out.index
                    || last_word !== exp_out.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_out.word, exp_out.index, exp_out.last,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] d, input logic h, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        has_byte <= h;
        is_last <= l;
        md5_predict(d, h, l);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_message(input int len, input logic fill, input logic [7:0] fill_val);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(fill ? fill_val : 8'($urandom), 1'b1, 1'b0);
        end
        if ($urandom_range(1))
            send_item(fill ? fill_val : 8'($urandom), 1'b1, 1'b1);
        else
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    stim_row_t directed [] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 32'hd98c1dd4},
        '{8'h61, 1'b1, 1'b1, 1'b1, 32'hb975c10c},
        '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0}
    };

    initial
    begin
        int phase_len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        has_byte = 1'b0;
        is_last = 1'b0;
        out_ready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        md5_restart();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].known)
                known_word0.push_back(directed[i].dig0);
            send_item(directed[i].data, directed[i].has, directed[i].last);
        end
        // padding boundaries: 54 to 56 and 63 to 64 byte messages
        send_message(54, 1'b1, 8'hff);
        send_message(55, 1'b0, 8'h00);
        send_message(63, 1'b1, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 23) : 0;
            recv_stall_pct = (ph == 2) ? 64 : (ph == 3 ? 23 : 0);
            phase_len = 0;
            while (phase_len < 32)
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(70, 130) : $urandom_range(0, 20);
                send_message(len, 1'b0, 8'h00);
                phase_len += len + 1;
            end
        end
        in_valid <= 1'b0;

        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
